### rtl/core/e2q_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_pkg: shared constants for the Euler to quaternion converter
// Default widths, fixed-point formats and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int QUAT_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // CORDIC datapath: x/y in Q30, z on a circle of 2^33
    localparam int XY_W = 32;
    localparam int Z_W  = 34;
    localparam int ATAN_W = 30;
    localparam int LANES = 3;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;

    // atan(2^-k) on a circle of 2^32
    localparam logic [ATAN_W-1:0] ATAN_TAB [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1,         30'd1,         30'd0
    };

endpackage

### rtl/core/e2q_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_if: valid/ready channels of the Euler to quaternion converter
// One interface for the angle beat and one for the quaternion beat.
// ----------------------------------------------------------------------------
interface e2q_ang_if #(
    parameter int ANGLE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;

    modport source (output valid, output roll_angle, output pitch_angle,
                    output yaw_angle, input ready);
    modport sink   (input valid, input roll_angle, input pitch_angle,
                    input yaw_angle, output ready);
endinterface

interface e2q_quat_if #(
    parameter int QUAT_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic signed [QUAT_BITS-1:0] quat_w;
    logic signed [QUAT_BITS-1:0] quat_x;
    logic signed [QUAT_BITS-1:0] quat_y;
    logic signed [QUAT_BITS-1:0] quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, output ready);
endinterface

### rtl/core/euler_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion: roll/pitch/yaw binary angles to ZYX unit quaternion
// Pipeline: input stage, CORDIC stages, two multiplier stages, output stage.
// Throughput: one beat per cycle while the output is not stalled; the
// CORDIC stages and the two multiplier stages each take a new beat every cycle.
// A stalled output freezes the whole pipeline; nothing is dropped.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
    parameter int ANGLE_BITS    = e2q_pkg::ANGLE_BITS_DEF,
    parameter int QUAT_BITS     = e2q_pkg::QUAT_BITS_DEF,
    parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    e2q_ang_if.sink     i_ang,
    e2q_quat_if.source  o_quat
);
    import e2q_pkg::*;

    localparam int P_W   = 2 * XY_W;
    localparam int SUM_W = P_W + 1;
    localparam int SH    = 61 - QUAT_BITS;
    localparam int R_W   = SUM_W + 1;
    localparam logic signed [R_W-1:0] RND = R_W'(1) <<< (SH - 1);
    localparam logic signed [R_W-1:0] Q_HI = (R_W'(1) <<< (QUAT_BITS - 1)) - R_W'(1);
    localparam logic signed [R_W-1:0] Q_LO = -(R_W'(1) <<< (QUAT_BITS - 1));
    localparam logic signed [P_W-1:0] P_RND = P_W'(1) <<< 29;

    logic w_adv;
    logic r_out_v;

    assign w_adv       = !r_out_v || o_quat.ready;
    assign i_ang.ready = w_adv;

    // input stage: half angle on circle of 2^33
    logic                r_in_v;
    logic signed [Z_W-1:0] r_z0 [LANES];
    logic signed [ANGLE_BITS-1:0] w_ang [LANES];

    assign w_ang[0] = i_ang.roll_angle;
    assign w_ang[1] = i_ang.pitch_angle;
    assign w_ang[2] = i_ang.yaw_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_adv) begin
            r_in_v <= i_ang.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int l = 0; l < LANES; l++) begin
                r_z0[l] <= Z_W'(w_ang[l]) <<< (32 - ANGLE_BITS);
            end
        end
    end

    // CORDIC pipeline, three lanes side by side
    logic                  r_cv [CORDIC_STAGES];
    logic signed [XY_W-1:0] r_cx [CORDIC_STAGES][LANES];
    logic signed [XY_W-1:0] r_cy [CORDIC_STAGES][LANES];
    logic signed [Z_W-1:0]  r_cz [CORDIC_STAGES][LANES];

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_st
        localparam int K = g % 32;
        localparam logic signed [Z_W-1:0] ANG2 = Z_W'({ATAN_TAB[K], 1'b0});
        logic                   w_v;
        logic signed [XY_W-1:0] w_x [LANES];
        logic signed [XY_W-1:0] w_y [LANES];
        logic signed [Z_W-1:0]  w_z [LANES];

        always_comb begin
            if (g == 0) begin
                w_v = r_in_v;
                for (int l = 0; l < LANES; l++) begin
                    w_x[l] = CORDIC_GAIN;
                    w_y[l] = '0;
                    w_z[l] = r_z0[l];
                end
            end else begin
                w_v = r_cv[(g == 0) ? 0 : g - 1];
                for (int l = 0; l < LANES; l++) begin
                    w_x[l] = r_cx[(g == 0) ? 0 : g - 1][l];
                    w_y[l] = r_cy[(g == 0) ? 0 : g - 1][l];
                    w_z[l] = r_cz[(g == 0) ? 0 : g - 1][l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[g] <= 1'b0;
            end else if (w_adv) begin
                r_cv[g] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                for (int l = 0; l < LANES; l++) begin
                    if (!w_z[l][Z_W-1]) begin
                        r_cx[g][l] <= w_x[l] - (w_y[l] >>> K);
                        r_cy[g][l] <= w_y[l] + (w_x[l] >>> K);
                        r_cz[g][l] <= w_z[l] - ANG2;
                    end else begin
                        r_cx[g][l] <= w_x[l] + (w_y[l] >>> K);
                        r_cy[g][l] <= w_y[l] - (w_x[l] >>> K);
                        r_cz[g][l] <= w_z[l] + ANG2;
                    end
                end
            end
        end
    end

    localparam int LS = CORDIC_STAGES - 1;

    // first products: roll by pitch
    logic                  r_m1_v;
    logic signed [P_W-1:0] r_cc, r_ss, r_sc, r_cs;
    logic signed [XY_W-1:0] r_m1_cy, r_m1_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
        end else if (w_adv) begin
            r_m1_v <= r_cv[LS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cc    <= P_W'(r_cx[LS][0]) * P_W'(r_cx[LS][1]);
            r_ss    <= P_W'(r_cy[LS][0]) * P_W'(r_cy[LS][1]);
            r_sc    <= P_W'(r_cy[LS][0]) * P_W'(r_cx[LS][1]);
            r_cs    <= P_W'(r_cx[LS][0]) * P_W'(r_cy[LS][1]);
            r_m1_cy <= r_cx[LS][2];
            r_m1_sy <= r_cy[LS][2];
        end
    end

    // round to Q30, then times yaw
    logic signed [P_W-1:0] w_cc_n, w_ss_n, w_sc_n, w_cs_n;
    logic signed [XY_W-1:0] w_cc, w_ss, w_sc, w_cs;

    assign w_cc_n = (r_cc + P_RND) >>> 30;
    assign w_ss_n = (r_ss + P_RND) >>> 30;
    assign w_sc_n = (r_sc + P_RND) >>> 30;
    assign w_cs_n = (r_cs + P_RND) >>> 30;
    assign w_cc   = w_cc_n[XY_W-1:0];
    assign w_ss   = w_ss_n[XY_W-1:0];
    assign w_sc   = w_sc_n[XY_W-1:0];
    assign w_cs   = w_cs_n[XY_W-1:0];

    logic                  r_m2_v;
    logic signed [P_W-1:0] r_w0, r_w1, r_x0, r_x1, r_y0, r_y1, r_z0p, r_z1p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_v <= 1'b0;
        end else if (w_adv) begin
            r_m2_v <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_w0  <= P_W'(w_cc) * P_W'(r_m1_cy);
            r_w1  <= P_W'(w_ss) * P_W'(r_m1_sy);
            r_x0  <= P_W'(w_sc) * P_W'(r_m1_cy);
            r_x1  <= P_W'(w_cs) * P_W'(r_m1_sy);
            r_y0  <= P_W'(w_cs) * P_W'(r_m1_cy);
            r_y1  <= P_W'(w_sc) * P_W'(r_m1_sy);
            r_z0p <= P_W'(w_cc) * P_W'(r_m1_sy);
            r_z1p <= P_W'(w_ss) * P_W'(r_m1_cy);
        end
    end

    // sum, round and saturate
    function automatic logic signed [QUAT_BITS-1:0] fit(input logic signed [R_W-1:0] s);
        logic signed [R_W-1:0] r;
        r = (s + RND) >>> SH;
        if (r > Q_HI) begin
            r = Q_HI;
        end else if (r < Q_LO) begin
            r = Q_LO;
        end
        return r[QUAT_BITS-1:0];
    endfunction

    logic signed [QUAT_BITS-1:0] r_qw, r_qx, r_qy, r_qz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= r_m2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_qw <= fit(R_W'(r_w0) + R_W'(r_w1));
            r_qx <= fit(R_W'(r_x0) - R_W'(r_x1));
            r_qy <= fit(R_W'(r_y0) + R_W'(r_y1));
            r_qz <= fit(R_W'(r_z0p) - R_W'(r_z1p));
        end
    end

    assign o_quat.valid  = r_out_v;
    assign o_quat.quat_w = r_qw;
    assign o_quat.quat_x = r_qx;
    assign o_quat.quat_y = r_qy;
    assign o_quat.quat_z = r_qz;

`ifndef SYNTHESIS
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ang.ready |-> r_out_v)
        else $error("input held off with empty output register");

    a_beat_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ang.valid && i_ang.ready |=> r_in_v)
        else $error("accepted beat not captured");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_m2_v) && $stable(r_m1_v))
        else $error("pipeline moved during stall");
`endif

endmodule
